### hw/rtl/mesh_edge_adjacency_defines.svh
// Assertion macros shared by mea_ctrl and mea_dpath.
`ifndef MESH_EDGE_ADJACENCY_DEFINES_SVH
`define MESH_EDGE_ADJACENCY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mea_pkg.sv
`default_nettype none
package mea_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        last_face;
    logic [9:0]  face_index;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] face_count;
    logic        overflowed;
    logic [9:0]  neighbour_0;
    logic        linked_0;
    logic [9:0]  neighbour_1;
    logic        linked_1;
    logic [9:0]  neighbour_2;
    logic        linked_2;
  } result_t;

  typedef struct packed {
    logic accept;
    logic begin_mesh;
    logic edge_wr;
    logic e_inc;
    logic face_inc;
    logic ovf_set;
    logic idx_clr;
    logic idx_inc;
    logic swap_clr;
    logic sort_cmp;
    logic sort_flush;
    logic clr_wr;
    logic link_cmp;
    logic link_wr2;
    logic rd_cap;
    logic mark_closed;
    logic out_load;
    logic out_kind;
  } cmd_t;

  typedef struct packed {
    logic closed;
    logic room;
    logic last;
    logic i_last;
    logic n_zero;
    logic n_one;
    logic swapped;
    logic e_last;
    logic match;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### hw/rtl/mea_ram.sv
`default_nettype none
module mea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/mea_ctrl.sv
`default_nettype none
`include "mesh_edge_adjacency_defines.svh"
module mea_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire logic           item_action,
  output logic                item_ready,
  input  wire mea_pkg::stat_t stat,
  output mea_pkg::cmd_t       cmd
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_LOAD       = 14'b00000000000010,
    S_CALC       = 14'b00000000000100,
    S_SORT_RD    = 14'b00000000001000,
    S_SORT_CMP   = 14'b00000000010000,
    S_SORT_FLUSH = 14'b00000000100000,
    S_CLR        = 14'b00000001000000,
    S_LINK_RD    = 14'b00000010000000,
    S_LINK_CMP   = 14'b00000100000000,
    S_LINK_WR2   = 14'b00001000000000,
    S_REPORT     = 14'b00010000000000,
    S_RD_A       = 14'b00100000000000,
    S_RD_D       = 14'b01000000000000,
    S_RD_OUT     = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept     = 1'b1;
          cmd.begin_mesh = (item_action == mea_pkg::ACT_LOAD) && stat.closed;
          state_next     = (item_action == mea_pkg::ACT_LOAD) ? S_LOAD : S_RD_A;
        end
      end
      S_LOAD: begin
        if (!stat.room) begin
          cmd.ovf_set = 1'b1;
          state_next  = stat.last ? S_CALC : S_IDLE;
        end else begin
          cmd.edge_wr = 1'b1;
          if (stat.e_last) begin
            cmd.face_inc = 1'b1;
            state_next   = stat.last ? S_CALC : S_IDLE;
          end else begin
            cmd.e_inc = 1'b1;
          end
        end
      end
      S_CALC: begin
        cmd.idx_clr  = 1'b1;
        cmd.swap_clr = 1'b1;
        if (stat.n_zero) begin
          state_next = S_REPORT;
        end else if (stat.n_one) begin
          state_next = S_CLR;
        end else begin
          state_next = S_SORT_RD;
        end
      end
      S_SORT_RD: begin
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.sort_cmp = 1'b1;
        if (stat.i_last) begin
          state_next = S_SORT_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SORT_RD;
        end
      end
      S_SORT_FLUSH: begin
        cmd.sort_flush = 1'b1;
        cmd.idx_clr    = 1'b1;
        cmd.swap_clr   = 1'b1;
        state_next     = stat.swapped ? S_SORT_RD : S_CLR;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.i_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_LINK_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LINK_RD: begin
        state_next = S_LINK_CMP;
      end
      S_LINK_CMP: begin
        cmd.link_cmp = 1'b1;
        if (stat.match) begin
          state_next = S_LINK_WR2;
        end else if (stat.i_last) begin
          state_next = S_REPORT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LINK_RD;
        end
      end
      S_LINK_WR2: begin
        cmd.link_wr2 = 1'b1;
        if (stat.i_last) begin
          state_next = S_REPORT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LINK_RD;
        end
      end
      S_REPORT: begin
        cmd.mark_closed = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = mea_pkg::KIND_DONE;
          state_next   = S_IDLE;
        end
      end
      S_RD_A: begin
        state_next = S_RD_D;
      end
      S_RD_D: begin
        cmd.rd_cap = 1'b1;
        if (stat.e_last) begin
          state_next = S_RD_OUT;
        end else begin
          cmd.e_inc  = 1'b1;
          state_next = S_RD_A;
        end
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = mea_pkg::KIND_READ;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MEA_ASSERT_NOW(a_edge_room, cmd.edge_wr, stat.room, "Edge written with the store full.")
  `MEA_ASSERT_NOW(a_out_free, cmd.out_load, stat.out_free, "Result loaded over a pending one.")
  `MEA_ASSERT_NEXT(a_sort_end, (state == S_SORT_FLUSH) && !stat.swapped, state == S_CLR,
    "Sort did not end after a clean pass.")

endmodule
`default_nettype wire

### hw/rtl/mea_dpath.sv
`default_nettype none
`include "mesh_edge_adjacency_defines.svh"
module mea_dpath #(
  parameter int MAX_FACES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mea_pkg::item_t   item,
  input  wire mea_pkg::cmd_t    cmd,
  output mea_pkg::stat_t        stat,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output mea_pkg::result_t      result
);

  localparam int FB    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CB    = $clog2(MAX_FACES + 1);
  localparam int SLOTS = 3 * MAX_FACES;
  localparam int SB    = $clog2(SLOTS);
  localparam int NB    = $clog2(SLOTS + 1);
  localparam int KB    = 2 * VERTEX_BITS + FB + 2;
  localparam int LB    = 11;

  mea_pkg::item_t   item_q;
  logic [CB-1:0]    count;
  logic             ovf;
  logic             closed;
  logic [SB-1:0]    idx;
  logic [1:0]       e;
  logic             swapped;
  logic [KB-1:0]    hold;
  logic [KB-1:0]    other;
  logic [LB-1:0]    links [3];

  logic [NB-1:0]    n;
  logic [VERTEX_BITS-1:0] va, vb, vc, p, q, lo, hi;
  logic [KB-1:0]    new_key;
  logic [KB-1:0]    erdata, ewdata;
  logic [SB-1:0]    ewaddr;
  logic             ewe;
  logic [LB-1:0]    lrdata, lwdata;
  logic [SB-1:0]    lwaddr, lraddr;
  logic             lwe;
  logic             less;
  logic [31:0]      cnt32, nb_cur32, nb_oth32;
  logic             visible;
  mea_pkg::result_t result_next;

  function automatic logic [SB-1:0] key_slot(input logic [KB-1:0] k);
    logic [31:0] f;
    f = 32'(k[FB+1:2]);
    return SB'((f << 1) + f + 32'(k[1:0]));
  endfunction

  assign n   = NB'((32'(count) << 1) + 32'(count));
  assign va  = item_q.vertex_a[VERTEX_BITS-1:0];
  assign vb  = item_q.vertex_b[VERTEX_BITS-1:0];
  assign vc  = item_q.vertex_c[VERTEX_BITS-1:0];

  always_comb begin
    case (e)
      2'd0:    begin p = va; q = vb; end
      2'd1:    begin p = vb; q = vc; end
      default: begin p = vc; q = va; end
    endcase
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
  end

  assign new_key = {lo, hi, FB'(count), e};
  assign less    = erdata < hold;

  always_comb begin
    ewe    = 1'b0;
    ewaddr = idx;
    ewdata = hold;
    if (cmd.edge_wr) begin
      ewe    = 1'b1;
      ewaddr = SB'((32'(count) << 1) + 32'(count) + 32'(e));
      ewdata = new_key;
    end else if (cmd.sort_cmp && (idx != '0)) begin
      ewe    = 1'b1;
      ewaddr = idx - SB'(1);
      ewdata = less ? erdata : hold;
    end else if (cmd.sort_flush) begin
      ewe = 1'b1;
    end
  end

  mea_ram #(.WIDTH(KB), .DEPTH(SLOTS)) u_edge_ram (
    .clk   (clk),
    .we    (ewe),
    .waddr (ewaddr),
    .wdata (ewdata),
    .raddr (idx),
    .rdata (erdata)
  );

  assign nb_cur32 = 32'(erdata[FB+1:2]);
  assign nb_oth32 = 32'(other[FB+1:2]);

  always_comb begin
    lwe    = 1'b0;
    lwaddr = idx;
    lwdata = '0;
    if (cmd.clr_wr) begin
      lwe = 1'b1;
    end else if (cmd.link_cmp && stat.match) begin
      lwe    = 1'b1;
      lwaddr = key_slot(hold);
      lwdata = {nb_cur32[9:0], 1'b1};
    end else if (cmd.link_wr2) begin
      lwe    = 1'b1;
      lwaddr = key_slot(hold);
      lwdata = {nb_oth32[9:0], 1'b1};
    end
  end

  assign lraddr = SB'((32'(item_q.face_index) << 1) + 32'(item_q.face_index) + 32'(e));

  mea_ram #(.WIDTH(LB), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata (lwdata),
    .raddr (lraddr),
    .rdata (lrdata)
  );

  assign stat.closed   = closed;
  assign stat.room     = 32'(count) < 32'(MAX_FACES);
  assign stat.last     = item_q.last_face;
  assign stat.i_last   = (32'(idx) + 32'd1) == 32'(n);
  assign stat.n_zero   = (n == '0);
  assign stat.n_one    = (32'(n) == 32'd1);
  assign stat.swapped  = swapped;
  assign stat.e_last   = (e == 2'd2);
  assign stat.match    = (idx != '0) && (erdata[KB-1:FB+2] == hold[KB-1:FB+2]);
  assign stat.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ovf     <= 1'b0;
      closed  <= 1'b0;
      swapped <= 1'b0;
      idx     <= '0;
      e       <= '0;
    end else begin
      if (cmd.begin_mesh) begin
        count  <= '0;
        ovf    <= 1'b0;
        closed <= 1'b0;
      end
      if (cmd.accept) begin
        e <= '0;
      end else if (cmd.e_inc) begin
        e <= e + 2'd1;
      end
      if (cmd.face_inc) begin
        count <= count + CB'(1);
      end
      if (cmd.ovf_set) begin
        ovf <= 1'b1;
      end
      if (cmd.mark_closed) begin
        closed <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SB'(1);
      end
      if (cmd.swap_clr) begin
        swapped <= 1'b0;
      end else if (cmd.sort_cmp && (idx != '0) && less) begin
        swapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= item;
    end
    if (cmd.sort_cmp) begin
      if ((idx == '0) || !less) begin
        hold <= erdata;
      end
    end else if (cmd.link_cmp) begin
      hold  <= erdata;
      other <= hold;
    end
    if (cmd.rd_cap) begin
      links[e] <= lrdata;
    end
  end

  assign cnt32   = 32'(count);
  assign visible = closed && (32'(item_q.face_index) < cnt32);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    result_next             = '0;
    result_next.result_kind = cmd.out_kind;
    result_next.face_count  = cnt32[10:0];
    result_next.overflowed  = ovf;
    if ((cmd.out_kind == mea_pkg::KIND_READ) && visible) begin
      result_next.linked_0    = links[0][0];
      result_next.neighbour_0 = links[0][0] ? links[0][10:1] : 10'd0;
      result_next.linked_1    = links[1][0];
      result_next.neighbour_1 = links[1][0] ? links[1][10:1] : 10'd0;
      result_next.linked_2    = links[2][0];
      result_next.neighbour_2 = links[2][0] ? links[2][10:1] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= result_next;
    end
  end

  `MEA_ASSERT_NOW(a_count_max, 1'b1, 32'(count) <= 32'(MAX_FACES), "Face count past capacity.")
  `MEA_ASSERT_NOW(a_link_addr, lwe, 32'(lwaddr) < 32'(n), "Link write outside the mesh.")

endmodule
`default_nettype wire

### hw/rtl/mesh_edge_adjacency.sv
`default_nettype none
// Triangle mesh adjacency by edge sorting. Load transactions store one face each, writing
// its edges to the edge memory after acceptance; loads past MAX_FACES are dropped
// and flagged. The load marked last starts the computation: with n = 3 * faces edges, a
// bubble sort over the edge memory, which has one read and one write port, runs up to n
// passes, stopping after the first pass without exchanges, then the n entries of the link
// memory are cleared and a pass over the sorted edges builds the links, after which a done
// report is given. A read transaction makes three reads of the link memory. New
// transactions are taken while a result waits in the output register.
module mesh_edge_adjacency #(
  parameter int MAX_FACES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire mea_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output mea_pkg::result_t      result
);

  mea_pkg::cmd_t  cmd;
  mea_pkg::stat_t stat;

  mea_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  mea_dpath #(.MAX_FACES(MAX_FACES), .VERTEX_BITS(VERTEX_BITS)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
